### src/epws_pkg.sv
package epws_pkg;

  localparam int unsigned RowW  = 10;
  localparam int unsigned ColW  = 7;
  localparam int unsigned AreaW = 17;
  localparam int unsigned StepW = 5;

  localparam logic [RowW-1:0] PanelRowsRst = 10'd480;
  localparam logic [ColW-1:0] RowBytesRst  = 7'd100;

  localparam logic [0:0] CfgPanelRows = 1'b0;
  localparam logic [0:0] CfgRowBytes  = 1'b1;

  localparam logic [0:0] OpOpen  = 1'b0;
  localparam logic [0:0] OpPixel = 1'b1;

  localparam logic [1:0] StatusOk       = 2'd0;
  localparam logic [1:0] StatusRejected = 2'd1;
  localparam logic [1:0] StatusNoWindow = 2'd2;

  localparam logic [7:0] CmdDriverOutput = 8'h18;
  localparam logic [7:0] DatTempSensor   = 8'h80;
  localparam logic [7:0] CmdBorder       = 8'h3C;
  localparam logic [7:0] DatBorder       = 8'h80;
  localparam logic [7:0] CmdEntryMode    = 8'h11;
  localparam logic [7:0] DatEntryMode    = 8'h01;
  localparam logic [7:0] CmdXWindow      = 8'h44;
  localparam logic [7:0] CmdYWindow      = 8'h45;
  localparam logic [7:0] CmdXCursor      = 8'h4E;
  localparam logic [7:0] CmdYCursor      = 8'h4F;
  localparam logic [7:0] CmdWriteRam     = 8'h24;
  localparam logic [7:0] CmdUpdateCtrl   = 8'h22;
  localparam logic [7:0] DatUpdateCtrl   = 8'hFF;
  localparam logic [7:0] CmdMasterAct    = 8'h20;

  localparam logic [StepW-1:0] OpenLastStep   = 5'd22;
  localparam logic [StepW-1:0] UpdateLastStep = 5'd3;

  typedef enum logic [2:0] {
    JobReject    = 3'd0,
    JobNoWindow  = 3'd1,
    JobPixel     = 3'd2,
    JobPixelLast = 3'd3,
    JobOpen      = 3'd4
  } job_kind_e;

  typedef struct packed {
    logic [0:0]      op;
    logic [ColW-1:0] col_byte_start;
    logic [RowW-1:0] row_start;
    logic [ColW-1:0] col_byte_count;
    logic [RowW-1:0] row_count;
    logic [7:0]      pixel_byte;
  } item_t;

  typedef struct packed {
    logic       is_data;
    logic [7:0] out_byte;
    logic       last;
    logic [1:0] status;
  } result_t;

  typedef struct packed {
    job_kind_e       kind;
    logic [7:0]      pixel;
    logic [RowW-1:0] xs;
    logic [RowW-1:0] xe;
    logic [RowW-1:0] hi;
    logic [RowW-1:0] lo;
  } job_t;

endpackage

### src/epws_front.sv
module epws_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [0:0]                    cfg_idx_i,
  input  logic [epws_pkg::RowW-1:0]     cfg_wdata_i,
  input  logic                          accept_i,
  input  epws_pkg::item_t               item_i,
  output epws_pkg::job_t                job_o
);

  logic [epws_pkg::RowW-1:0]  panel_rows_q;
  logic [epws_pkg::ColW-1:0]  row_bytes_q;
  logic                       open_q, open_d;
  logic [epws_pkg::AreaW-1:0] remaining_q, remaining_d;

  logic [epws_pkg::ColW:0]    sum_x;
  logic [epws_pkg::RowW:0]    sum_y;
  logic [epws_pkg::ColW-1:0]  x_end;
  logic [epws_pkg::AreaW-1:0] area;
  logic                       reject;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      panel_rows_q <= epws_pkg::PanelRowsRst;
      row_bytes_q  <= epws_pkg::RowBytesRst;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == epws_pkg::CfgPanelRows) begin
        panel_rows_q <= cfg_wdata_i;
      end else begin
        row_bytes_q <= cfg_wdata_i[epws_pkg::ColW-1:0];
      end
    end
  end

  always_comb begin
    sum_x  = {1'b0, item_i.col_byte_start} + {1'b0, item_i.col_byte_count};
    sum_y  = {1'b0, item_i.row_start} + {1'b0, item_i.row_count};
    x_end  = sum_x[epws_pkg::ColW-1:0] - epws_pkg::ColW'(1);
    area   = epws_pkg::AreaW'(item_i.col_byte_count) * epws_pkg::AreaW'(item_i.row_count);
    reject = (item_i.col_byte_count == '0) || (item_i.row_count == '0) ||
             (sum_x > {1'b0, row_bytes_q}) || (sum_y > {1'b0, panel_rows_q});

    job_o.pixel = item_i.pixel_byte;
    job_o.xs    = {item_i.col_byte_start, 3'b000};
    job_o.xe    = {x_end, 3'b111};
    job_o.hi    = panel_rows_q - epws_pkg::RowW'(1) - item_i.row_start;
    job_o.lo    = panel_rows_q - item_i.row_start - item_i.row_count;

    open_d      = open_q;
    remaining_d = remaining_q;
    if (item_i.op == epws_pkg::OpOpen) begin
      if (reject) begin
        job_o.kind = epws_pkg::JobReject;
      end else begin
        job_o.kind  = epws_pkg::JobOpen;
        open_d      = 1'b1;
        remaining_d = area;
      end
    end else if (!open_q || remaining_q == '0) begin
      job_o.kind = epws_pkg::JobNoWindow;
    end else begin
      remaining_d = remaining_q - epws_pkg::AreaW'(1);
      if (remaining_q == epws_pkg::AreaW'(1)) begin
        job_o.kind = epws_pkg::JobPixelLast;
        open_d     = 1'b0;
      end else begin
        job_o.kind = epws_pkg::JobPixel;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q      <= 1'b0;
      remaining_q <= '0;
    end else if (accept_i) begin
      open_q      <= open_d;
      remaining_q <= remaining_d;
    end
  end

endmodule

### src/epws_queue.sv
module epws_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_i,
  input  epws_pkg::job_t wdata_i,
  input  logic           rd_i,
  output epws_pkg::job_t rdata_o,
  output logic           full_o,
  output logic           empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  epws_pkg::job_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_wr, do_rd;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_wr && !do_rd) begin
        count_q <= count_q + CntW'(1);
      end else if (do_rd && !do_wr) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

### src/epws_back.sv
module epws_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  epws_pkg::job_t    job_i,
  input  logic              job_empty_i,
  output logic              job_pop_o,
  input  logic              pop,
  output logic              empty,
  output epws_pkg::result_t res_o
);

  logic [epws_pkg::StepW-1:0] step_q;
  logic                       out_valid_q;
  epws_pkg::result_t          out_q;
  epws_pkg::result_t          res_d;
  logic [epws_pkg::StepW-1:0] last_step;
  logic                       load, emit;

  function automatic logic [7:0] lo_byte(input logic [epws_pkg::RowW-1:0] v);
    return v[7:0];
  endfunction

  function automatic logic [7:0] hi_byte(input logic [epws_pkg::RowW-1:0] v);
    return {6'b000000, v[epws_pkg::RowW-1:8]};
  endfunction

  always_comb begin
    res_d     = '{is_data: 1'b0, out_byte: 8'h00, last: 1'b1, status: epws_pkg::StatusOk};
    last_step = '0;
    case (job_i.kind)
      epws_pkg::JobReject: begin
        res_d.status = epws_pkg::StatusRejected;
      end
      epws_pkg::JobNoWindow: begin
        res_d.status = epws_pkg::StatusNoWindow;
      end
      epws_pkg::JobPixel: begin
        res_d.is_data  = 1'b1;
        res_d.out_byte = job_i.pixel;
      end
      epws_pkg::JobPixelLast: begin
        last_step  = epws_pkg::UpdateLastStep;
        res_d.last = (step_q == epws_pkg::UpdateLastStep);
        case (step_q)
          5'd0: begin
            res_d.is_data  = 1'b1;
            res_d.out_byte = job_i.pixel;
          end
          5'd1: res_d.out_byte = epws_pkg::CmdUpdateCtrl;
          5'd2: begin
            res_d.is_data  = 1'b1;
            res_d.out_byte = epws_pkg::DatUpdateCtrl;
          end
          default: res_d.out_byte = epws_pkg::CmdMasterAct;
        endcase
      end
      epws_pkg::JobOpen: begin
        last_step     = epws_pkg::OpenLastStep;
        res_d.last    = (step_q == epws_pkg::OpenLastStep);
        res_d.is_data = 1'b1;
        case (step_q)
          5'd0: begin
            res_d.is_data  = 1'b0;
            res_d.out_byte = epws_pkg::CmdDriverOutput;
          end
          5'd1: res_d.out_byte = epws_pkg::DatTempSensor;
          5'd2: begin
            res_d.is_data  = 1'b0;
            res_d.out_byte = epws_pkg::CmdBorder;
          end
          5'd3: res_d.out_byte = epws_pkg::DatBorder;
          5'd4: begin
            res_d.is_data  = 1'b0;
            res_d.out_byte = epws_pkg::CmdEntryMode;
          end
          5'd5: res_d.out_byte = epws_pkg::DatEntryMode;
          5'd6: begin
            res_d.is_data  = 1'b0;
            res_d.out_byte = epws_pkg::CmdXWindow;
          end
          5'd7:  res_d.out_byte = lo_byte(job_i.xs);
          5'd8:  res_d.out_byte = hi_byte(job_i.xs);
          5'd9:  res_d.out_byte = lo_byte(job_i.xe);
          5'd10: res_d.out_byte = hi_byte(job_i.xe);
          5'd11: begin
            res_d.is_data  = 1'b0;
            res_d.out_byte = epws_pkg::CmdYWindow;
          end
          5'd12: res_d.out_byte = lo_byte(job_i.hi);
          5'd13: res_d.out_byte = hi_byte(job_i.hi);
          5'd14: res_d.out_byte = lo_byte(job_i.lo);
          5'd15: res_d.out_byte = hi_byte(job_i.lo);
          5'd16: begin
            res_d.is_data  = 1'b0;
            res_d.out_byte = epws_pkg::CmdXCursor;
          end
          5'd17: res_d.out_byte = lo_byte(job_i.xs);
          5'd18: res_d.out_byte = hi_byte(job_i.xs);
          5'd19: begin
            res_d.is_data  = 1'b0;
            res_d.out_byte = epws_pkg::CmdYCursor;
          end
          5'd20: res_d.out_byte = lo_byte(job_i.lo);
          5'd21: res_d.out_byte = hi_byte(job_i.lo);
          default: begin
            res_d.is_data  = 1'b0;
            res_d.out_byte = epws_pkg::CmdWriteRam;
          end
        endcase
      end
      default: begin
        res_d.status = epws_pkg::StatusNoWindow;
      end
    endcase
  end

  assign load      = !out_valid_q || pop;
  assign emit      = load && !job_empty_i;
  assign job_pop_o = emit && (step_q == last_step);
  assign empty     = !out_valid_q;
  assign res_o     = out_q;

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      step_q      <= '0;
    end else begin
      if (load) begin
        out_valid_q <= !job_empty_i;
      end
      if (emit) begin
        step_q <= (step_q == last_step) ? '0 : step_q + epws_pkg::StepW'(1);
      end
    end
  end

endmodule

### src/epaper_window_update_sequencer.sv
// Channel   Direction  Transfer when        Payload
// input     in         push && !full        item_i   (epws_pkg::item_t)
// result    out        pop && !empty        res_o    (epws_pkg::result_t)
// config    in         cfg_we_i             cfg_idx_i, cfg_wdata_i
//
// Each item is classified in the cycle it is taken and queued as one job.
// The back end emits one result per cycle unless a result is held or no job is
// queued: image bytes stream at one per cycle, an opened window yields 23
// results, a closing byte 4; results are registered from the job queue head.
// Reset clears the window state, the job queue and the result valid flag.
// A full job queue stalls input; a held result stalls the back end, then input.
module epaper_window_update_sequencer #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push,
  output logic                      full,
  input  epws_pkg::item_t           item_i,
  output logic                      empty,
  input  logic                      pop,
  output epws_pkg::result_t         res_o,
  input  logic                      cfg_we_i,
  input  logic [0:0]                cfg_idx_i,
  input  logic [epws_pkg::RowW-1:0] cfg_wdata_i
);

  epws_pkg::job_t new_job, head_job;
  logic           accept, q_empty, q_pop;

  assign accept = push && !full;

  epws_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .item_i      (item_i),
    .job_o       (new_job)
  );

  epws_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (accept),
    .wdata_i (new_job),
    .rd_i    (q_pop),
    .rdata_o (head_job),
    .full_o  (full),
    .empty_o (q_empty)
  );

  epws_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (head_job),
    .job_empty_i (q_empty),
    .job_pop_o   (q_pop),
    .pop         (pop),
    .empty       (empty),
    .res_o       (res_o)
  );

endmodule

### test/tb_epaper_window_update_sequencer.sv
`timescale 1ns / 100ps

class update_stream_board;
  logic [epws_pkg::RowW-1:0]  panel_rows;
  logic [epws_pkg::ColW-1:0]  row_bytes;
  bit                         window_open;
  logic [epws_pkg::AreaW-1:0] bytes_left;
  epws_pkg::result_t          due_bytes[$];
  int unsigned                bad_fields;

  function new();
    panel_rows  = epws_pkg::PanelRowsRst;
    row_bytes   = epws_pkg::RowBytesRst;
    window_open = 1'b0;
    bytes_left  = '0;
    bad_fields  = 0;
  endfunction

  function void set_reg(logic [0:0] idx, logic [epws_pkg::RowW-1:0] value);
    if (idx == epws_pkg::CfgPanelRows) begin
      panel_rows = value;
    end else begin
      row_bytes = value[epws_pkg::ColW-1:0];
    end
  endfunction

  function void queue_byte(bit dat, logic [7:0] b, bit last, logic [1:0] st);
    epws_pkg::result_t r;
    r.is_data  = dat;
    r.out_byte = b;
    r.last     = last;
    r.status   = st;
    due_bytes.push_back(r);
  endfunction

  function void note_item(epws_pkg::item_t it);
    int unsigned bx, y, bw, h, xs, xe, hi, lo;
    bx = it.col_byte_start;
    y  = it.row_start;
    bw = it.col_byte_count;
    h  = it.row_count;
    if (it.op == epws_pkg::OpOpen) begin
      if (bw == 0 || h == 0 || bx + bw > row_bytes || y + h > panel_rows) begin
        queue_byte(1'b0, 8'h00, 1'b1, epws_pkg::StatusRejected);
        return;
      end
      xs = bx * 8;
      xe = (bx + bw) * 8 - 1;
      hi = panel_rows - 1 - y;
      lo = panel_rows - y - h;
      queue_byte(1'b0, epws_pkg::CmdDriverOutput, 1'b0, epws_pkg::StatusOk);
      queue_byte(1'b1, epws_pkg::DatTempSensor, 1'b0, epws_pkg::StatusOk);
      queue_byte(1'b0, epws_pkg::CmdBorder, 1'b0, epws_pkg::StatusOk);
      queue_byte(1'b1, epws_pkg::DatBorder, 1'b0, epws_pkg::StatusOk);
      queue_byte(1'b0, epws_pkg::CmdEntryMode, 1'b0, epws_pkg::StatusOk);
      queue_byte(1'b1, epws_pkg::DatEntryMode, 1'b0, epws_pkg::StatusOk);
      queue_byte(1'b0, epws_pkg::CmdXWindow, 1'b0, epws_pkg::StatusOk);
      queue_byte(1'b1, 8'(xs), 1'b0, epws_pkg::StatusOk);
      queue_byte(1'b1, 8'(xs >> 8), 1'b0, epws_pkg::StatusOk);
      queue_byte(1'b1, 8'(xe), 1'b0, epws_pkg::StatusOk);
      queue_byte(1'b1, 8'(xe >> 8), 1'b0, epws_pkg::StatusOk);
      queue_byte(1'b0, epws_pkg::CmdYWindow, 1'b0, epws_pkg::StatusOk);
      queue_byte(1'b1, 8'(hi), 1'b0, epws_pkg::StatusOk);
      queue_byte(1'b1, 8'(hi >> 8), 1'b0, epws_pkg::StatusOk);
      queue_byte(1'b1, 8'(lo), 1'b0, epws_pkg::StatusOk);
      queue_byte(1'b1, 8'(lo >> 8), 1'b0, epws_pkg::StatusOk);
      queue_byte(1'b0, epws_pkg::CmdXCursor, 1'b0, epws_pkg::StatusOk);
      queue_byte(1'b1, 8'(xs), 1'b0, epws_pkg::StatusOk);
      queue_byte(1'b1, 8'(xs >> 8), 1'b0, epws_pkg::StatusOk);
      queue_byte(1'b0, epws_pkg::CmdYCursor, 1'b0, epws_pkg::StatusOk);
      queue_byte(1'b1, 8'(lo), 1'b0, epws_pkg::StatusOk);
      queue_byte(1'b1, 8'(lo >> 8), 1'b0, epws_pkg::StatusOk);
      queue_byte(1'b0, epws_pkg::CmdWriteRam, 1'b1, epws_pkg::StatusOk);
      window_open = 1'b1;
      bytes_left  = epws_pkg::AreaW'(bw * h);
    end else if (!window_open || bytes_left == 0) begin
      queue_byte(1'b0, 8'h00, 1'b1, epws_pkg::StatusNoWindow);
    end else begin
      bytes_left = bytes_left - 1'b1;
      if (bytes_left != 0) begin
        queue_byte(1'b1, it.pixel_byte, 1'b1, epws_pkg::StatusOk);
      end else begin
        queue_byte(1'b1, it.pixel_byte, 1'b0, epws_pkg::StatusOk);
        queue_byte(1'b0, epws_pkg::CmdUpdateCtrl, 1'b0, epws_pkg::StatusOk);
        queue_byte(1'b1, epws_pkg::DatUpdateCtrl, 1'b0, epws_pkg::StatusOk);
        queue_byte(1'b0, epws_pkg::CmdMasterAct, 1'b1, epws_pkg::StatusOk);
        window_open = 1'b0;
      end
    end
  endfunction

  function void check_byte(epws_pkg::result_t got);
    epws_pkg::result_t want;
    if (due_bytes.size() == 0) begin
      $error("result transfer with nothing pending: out_byte %h", got.out_byte);
      bad_fields++;
      return;
    end
    want = due_bytes.pop_front();
    if (got.is_data !== want.is_data) begin
      $error("is_data: expected %0d, actual %0d", want.is_data, got.is_data);
      bad_fields++;
    end
    if (got.out_byte !== want.out_byte) begin
      $error("out_byte: expected %h, actual %h", want.out_byte, got.out_byte);
      bad_fields++;
    end
    if (got.last !== want.last) begin
      $error("last: expected %0d, actual %0d", want.last, got.last);
      bad_fields++;
    end
    if (got.status !== want.status) begin
      $error("status: expected %0d, actual %0d", want.status, got.status);
      bad_fields++;
    end
  endfunction
endclass

module tb_epaper_window_update_sequencer;
  localparam int unsigned HoldCycles = 300;

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      push;
  logic                      full;
  epws_pkg::item_t           item_i;
  logic                      empty;
  logic                      pop;
  epws_pkg::result_t         res_o;
  logic                      cfg_we_i;
  logic [0:0]                cfg_idx_i;
  logic [epws_pkg::RowW-1:0] cfg_wdata_i;

  update_stream_board sb;
  int unsigned        send_idle_pct = 0;
  int unsigned        pop_stall_pct = 0;
  bit                 long_hold = 1'b0;

  epaper_window_update_sequencer uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .item_i      (item_i),
    .empty       (empty),
    .pop         (pop),
    .res_o       (res_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #1 clk_i = ~clk_i;

  function automatic epws_pkg::item_t make_item(input int unsigned op, bx, y, bw, h, px);
    epws_pkg::item_t it;
    it.op             = 1'(op);
    it.col_byte_start = epws_pkg::ColW'(bx);
    it.row_start      = epws_pkg::RowW'(y);
    it.col_byte_count = epws_pkg::ColW'(bw);
    it.row_count      = epws_pkg::RowW'(h);
    it.pixel_byte     = 8'(px);
    return it;
  endfunction

  task automatic send_item(input epws_pkg::item_t it);
    bit taken;
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push   <= 1'b1;
    item_i <= it;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk_i);
      taken = !full;
      if (taken) begin
        sb.note_item(it);
      end
      @(negedge clk_i);
    end
  endtask

  task automatic wait_drain();
    push <= 1'b0;
    while (sb.due_bytes.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_config(input int unsigned rows, lines);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= epws_pkg::CfgPanelRows;
    cfg_wdata_i <= epws_pkg::RowW'(rows);
    @(negedge clk_i);
    cfg_idx_i   <= epws_pkg::CfgRowBytes;
    cfg_wdata_i <= epws_pkg::RowW'(lines);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_reg(epws_pkg::CfgPanelRows, epws_pkg::RowW'(rows));
    sb.set_reg(epws_pkg::CfgRowBytes, epws_pkg::RowW'(lines));
  endtask

  task automatic random_items(input int unsigned count);
    int unsigned sent, roll, bw, h, area, cut, lim_w, lim_h;
    sent = 0;
    while (sent < count) begin
      roll = $urandom_range(99);
      if (roll < 70) begin
        lim_w = (sb.row_bytes < 4) ? sb.row_bytes : 4;
        lim_h = (sb.panel_rows < 4) ? sb.panel_rows : 4;
        bw = $urandom_range(1, lim_w);
        h  = $urandom_range(1, lim_h);
        send_item(make_item(epws_pkg::OpOpen, $urandom_range(0, sb.row_bytes - bw),
                            $urandom_range(0, sb.panel_rows - h), bw, h, $urandom));
        sent++;
        area = bw * h;
        cut  = ($urandom_range(9) == 0) ? $urandom_range(0, area - 1) : area;
        for (int unsigned k = 0; k < cut; k++) begin
          if ($urandom_range(19) == 0) begin
            send_item(make_item($urandom, $urandom, $urandom, $urandom, $urandom,
                                $urandom));
            sent++;
          end
          send_item(make_item(epws_pkg::OpPixel, $urandom, $urandom, $urandom, $urandom,
                              $urandom));
          sent++;
        end
      end else if (roll < 85) begin
        send_item(make_item($urandom, $urandom, $urandom, $urandom, $urandom, $urandom));
        sent++;
      end else begin
        send_item(make_item(epws_pkg::OpPixel, $urandom, $urandom, $urandom, $urandom,
                            $urandom));
        sent++;
      end
    end
  endtask

  task automatic run_phase(input int unsigned rows, lines, idle, stall, count,
                           input bit hold);
    wait_drain();
    write_config(rows, lines);
    send_idle_pct = idle;
    pop_stall_pct = stall;
    long_hold     = hold;
    random_items(count);
  endtask

  initial begin : receiver
    pop = 1'b0;
    forever begin
      @(negedge clk_i);
      if (long_hold) begin
        pop <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        long_hold = 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= pop_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      sb.check_byte(res_o);
    end
  end

  initial begin : watchdog
    #1000000;
    $display("Mismatches found");
    $finish;
  end

  initial begin : stimulus
    sb          = new();
    rst_ni      = 1'b0;
    push        = 1'b0;
    item_i      = '0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = epws_pkg::CfgPanelRows;
    cfg_wdata_i = '0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset geometry: rejections, exact fit, reopen and reject inside a window.
    send_item(make_item(epws_pkg::OpPixel, 0, 0, 0, 0, 8'h3C));
    send_item(make_item(epws_pkg::OpOpen, 0, 0, 0, 1, 0));
    send_item(make_item(epws_pkg::OpOpen, 0, 0, 1, 0, 0));
    send_item(make_item(epws_pkg::OpOpen, 99, 0, 2, 1, 0));
    send_item(make_item(epws_pkg::OpOpen, 0, 479, 1, 2, 0));
    send_item(make_item(epws_pkg::OpOpen, 99, 479, 1, 1, 0));
    send_item(make_item(epws_pkg::OpPixel, 0, 0, 0, 0, 8'hFF));
    send_item(make_item(epws_pkg::OpOpen, 0, 0, 1, 2, 0));
    send_item(make_item(epws_pkg::OpPixel, 0, 0, 0, 0, 8'h00));
    send_item(make_item(epws_pkg::OpOpen, 5, 5, 0, 3, 0));
    send_item(make_item(epws_pkg::OpPixel, 0, 0, 0, 0, 8'hA5));
    send_item(make_item(epws_pkg::OpOpen, 1, 2, 2, 2, 0));
    send_item(make_item(epws_pkg::OpPixel, 0, 0, 0, 0, 8'h5A));
    send_item(make_item(epws_pkg::OpOpen, 0, 0, 1, 1, 0));
    send_item(make_item(epws_pkg::OpPixel, 0, 0, 0, 0, 8'h81));
    send_item(make_item(epws_pkg::OpPixel, 0, 0, 0, 0, 8'h7E));

    wait_drain();
    write_config(1023, 127);
    send_item(make_item(epws_pkg::OpOpen, 126, 1022, 1, 1, 8'hFF));
    send_item(make_item(epws_pkg::OpPixel, 127, 1023, 127, 1023, 8'hC3));
    send_item(make_item(epws_pkg::OpOpen, 127, 1023, 127, 1023, 8'hFF));

    // Zero registers reject every window.
    wait_drain();
    write_config(0, 0);
    send_item(make_item(epws_pkg::OpOpen, 0, 0, 1, 1, 0));

    wait_drain();
    write_config(1, 1);
    send_item(make_item(epws_pkg::OpOpen, 0, 0, 1, 1, 0));
    send_item(make_item(epws_pkg::OpPixel, 0, 0, 0, 0, 8'h69));
    send_item(make_item(epws_pkg::OpOpen, 0, 0, 1, 2, 0));

    run_phase(480, 100, 0, 0, 60, 1'b0);
    run_phase(1023, 127, 82, 0, 55, 1'b0);
    run_phase(1, 1, 0, 82, 45, 1'b0);
    run_phase($urandom_range(1, 1023), $urandom_range(1, 127), 37, 37, 60, 1'b0);
    run_phase($urandom_range(1, 1023), $urandom_range(1, 127), 0, 0, 60, 1'b1);

    wait_drain();
    repeat (30) @(negedge clk_i);
    if (sb.bad_fields == 0 && sb.due_bytes.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
